### rtl/core/lzss_flag_nibble_decoder_core_assert.svh
// Assertion macros for the LZSS flag/nibble decoder core.
`ifndef LZSS_FLAG_NIBBLE_DECODER_CORE_ASSERT_SVH
`define LZSS_FLAG_NIBBLE_DECODER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked outside reset.
`define LFND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, checked outside reset.
`define LFND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LFND_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define LFND_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### rtl/core/lfnd_pkg.sv
// Shared types and constants for the LZSS flag/nibble decoder core.
`timescale 1ns / 1ps
`default_nettype none

package lfnd_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 20;
    localparam int HDR_W    = 3;
    localparam int SLOT_W   = 4;
    localparam int CNT_W    = 5;

    // History window
    localparam int WIN_DEPTH = 4096;
    localparam int WIN_AW    = $clog2(WIN_DEPTH);

    // Output length ceiling
    localparam logic [LEN_W-1:0] MAX_OUTPUT = LEN_W'(524288);

    // Header length in bytes, slots per control byte, minimum copy length
    localparam logic [HDR_W-1:0]  HDR_BYTES  = HDR_W'(4);
    localparam logic [SLOT_W-1:0] SLOTS      = SLOT_W'(8);
    localparam logic [CNT_W-1:0]  COPY_MIN   = CNT_W'(3);

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              in_last;
    } t_in;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              run_end;
        logic              final_flag;
        logic [LEN_W-1:0]  out_length;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LIT,
        ST_CP_RD,
        ST_CP_WR,
        ST_END
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic hdr_update;
        logic load_flags;
        logic store_low;
        logic start_copy;
        logic copy_read;
        logic emit_lit;
        logic emit_copy;
        logic advance;
        logic emit_final;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic in_header;
        logic need_control;
        logic flag_lit;
        logic have_low;
        logic pos_lt_limit;
        logic copy_more;
        logic out_free;
        logic last;
    } t_sts;

endpackage

`default_nettype wire

### rtl/core/lzss_flag_nibble_decoder_core.sv
// Top level of the LZSS flag/nibble decoder: controller, datapath and checks.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in) takes the compressed stream
//   one byte per transfer, four length header bytes first; in_last marks the
//   final byte. Output channel (o_out_valid / i_out_stall / o_out) gives the
//   decoded bytes, then one closing result with final_flag set that carries
//   the produced length. run_end marks the last result caused by an input.
//   Timing: one input byte at a time. Header, control and low code bytes pass
//   through the IDLE, DECODE and END states; a literal adds the LIT state, in
//   which its result is registered. A code word copies up to 18 bytes, each
//   in a CP_RD then CP_WR state pair: a registered read of the 4096-entry
//   history RAM ahead of each write. The closing result is loaded in END.
//   Reset (synchronous, active low) clears the stream state and the output
//   valid flag; the history RAM is not cleared and needs no clearing pass.
//   A stalled receiver holds the current result in the output register; the
//   block then waits before loading the next one and keeps o_in_stall high.
`timescale 1ns / 1ps
`default_nettype none
`include "lzss_flag_nibble_decoder_core_assert.svh"

module lzss_flag_nibble_decoder_core #(
    parameter int MAX_OUT_LEN = int'(lfnd_pkg::MAX_OUTPUT)
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  lfnd_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  wire            i_out_stall,
    output lfnd_pkg::t_out o_out
);

    import lfnd_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer
    lfnd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath
    lfnd_dp #(
        .MAX_OUT_LEN (MAX_OUT_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // Checks
    `LFND_ASSERT_NOW(a_emit_free, i_clk, i_rst_n,
        cmd.emit_lit || cmd.emit_copy || cmd.emit_final, sts.out_free,
        "result loaded over an untaken one")
    `LFND_ASSERT_NOW(a_read_in_run, i_clk, i_rst_n,
        cmd.copy_read, sts.copy_more, "history read past copy end")
    `LFND_ASSERT_NOW(a_final_ends, i_clk, i_rst_n,
        o_out_valid && o_out.final_flag, o_out.run_end, "closing result without run_end")
    `LFND_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n,
        i_in_valid && !o_in_stall, o_in_stall, "input taken while busy")

endmodule

`default_nettype wire

### rtl/core/lfnd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module lfnd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire [$clog2(DEPTH)-1:0]  i_waddr,
    input  wire [WIDTH-1:0]          i_wdata,
    input  wire                      i_re,
    input  wire [$clog2(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/lfnd_ctrl.sv
// Controller state machine: sequences parse, literal, copy and close steps.
`timescale 1ns / 1ps
`default_nettype none

module lfnd_ctrl (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_in_valid,
    output logic           o_in_stall,
    input  lfnd_pkg::t_sts i_sts,
    output lfnd_pkg::t_cmd o_cmd
);

    import lfnd_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (i_sts.in_header) begin
                    o_cmd.hdr_update = 1'b1;
                    n_state          = ST_END;
                end else if (i_sts.need_control) begin
                    o_cmd.load_flags = 1'b1;
                    n_state          = ST_END;
                end else if (i_sts.flag_lit) begin
                    if (i_sts.pos_lt_limit) begin
                        n_state = ST_LIT;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_state       = ST_END;
                    end
                end else if (!i_sts.have_low) begin
                    o_cmd.store_low = 1'b1;
                    n_state         = ST_END;
                end else begin
                    o_cmd.start_copy = 1'b1;
                    n_state          = ST_CP_RD;
                end
            end
            ST_LIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_lit = 1'b1;
                    o_cmd.advance  = 1'b1;
                    n_state        = ST_END;
                end
            end
            ST_CP_RD: begin
                if (i_sts.copy_more) begin
                    o_cmd.copy_read = 1'b1;
                    n_state         = ST_CP_WR;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_END;
                end
            end
            ST_CP_WR: begin
                if (i_sts.out_free) begin
                    o_cmd.emit_copy = 1'b1;
                    n_state         = ST_CP_RD;
                end
            end
            ST_END: begin
                if (!i_sts.last) begin
                    n_state = ST_IDLE;
                end else if (i_sts.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/lfnd_dp.sv
// Datapath: stream state, copy address math, history RAM and output register.
`timescale 1ns / 1ps
`default_nettype none

module lfnd_dp #(
    parameter int MAX_OUT_LEN = int'(lfnd_pkg::MAX_OUTPUT)
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  lfnd_pkg::t_in  i_in,
    input  wire            i_out_stall,
    output logic           o_out_valid,
    output lfnd_pkg::t_out o_out,
    input  lfnd_pkg::t_cmd i_cmd,
    output lfnd_pkg::t_sts o_sts
);

    import lfnd_pkg::*;

    localparam logic [LEN_W-1:0] WIN_SPAN = LEN_W'(WIN_DEPTH);
    localparam logic [LEN_W-1:0] LEN_CAP  = LEN_W'(MAX_OUT_LEN);
    localparam int SUM_W = 33;

    // Captured input
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;

    // Stream state
    logic [HDR_W-1:0]  r_hdr_cnt;
    logic [LEN_W-1:0]  r_limit;
    logic [BYTE_W-1:0] r_flags;
    logic [SLOT_W-1:0] r_slot;
    logic [BYTE_W-1:0] r_code_low;
    logic              r_have_low;
    logic [LEN_W-1:0]  r_pos;

    // Copy state
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [WIN_AW-1:0] r_off;
    logic              r_src_ok;

    // Output register
    logic              r_out_valid;
    t_out              r_out;

    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] copy_byte;
    logic [LEN_W-1:0]  base;
    logic [LEN_W-1:0]  src;
    logic [SUM_W-1:0]  hdr_sum;
    logic [SUM_W-1:0]  hdr_add;
    logic              out_free;
    logic              copy_last;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;

    // Header accumulate with clamp
    always_comb begin
        hdr_add = SUM_W'(r_byte) << {r_hdr_cnt[1:0], 3'b000};
        hdr_sum = SUM_W'(r_limit) + hdr_add;
    end

    // Copy source: window base from current position, then offset and index
    always_comb begin
        base = '0;
        if (r_pos > WIN_SPAN) begin
            base = {r_pos[LEN_W-1:WIN_AW], {WIN_AW{1'b0}}};
            if (r_pos[WIN_AW-1:0] < r_off) begin
                base = base - WIN_SPAN;
            end
        end
        src = base + LEN_W'(r_off) + LEN_W'(r_idx);
    end

    assign out_free  = !r_out_valid || !i_out_stall;
    assign copy_byte = r_src_ok ? ram_rdata : '0;
    assign copy_last = ((r_idx + CNT_W'(1)) == r_count)
                    || ((r_pos + LEN_W'(1)) == r_limit);

    // Status to controller
    always_comb begin
        o_sts.in_header    = (r_hdr_cnt < HDR_BYTES);
        o_sts.need_control = (r_slot == '0);
        o_sts.flag_lit     = r_flags[0];
        o_sts.have_low     = r_have_low;
        o_sts.pos_lt_limit = (r_pos < r_limit);
        o_sts.copy_more    = (r_idx < r_count) && (r_pos < r_limit);
        o_sts.out_free     = out_free;
        o_sts.last         = r_last;
    end

    // Input capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_byte <= i_in.in_byte;
            r_last <= i_in.in_last;
        end
    end

    // Stream control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.emit_final) begin
            r_hdr_cnt  <= '0;
            r_limit    <= '0;
            r_flags    <= '0;
            r_slot     <= '0;
            r_code_low <= '0;
            r_have_low <= 1'b0;
            r_pos      <= '0;
        end else begin
            if (i_cmd.hdr_update) begin
                r_limit   <= (hdr_sum > SUM_W'(LEN_CAP)) ? LEN_CAP
                                                         : hdr_sum[LEN_W-1:0];
                r_hdr_cnt <= r_hdr_cnt + HDR_W'(1);
            end
            if (i_cmd.load_flags) begin
                r_flags <= r_byte;
                r_slot  <= SLOTS;
            end
            if (i_cmd.store_low) begin
                r_code_low <= r_byte;
                r_have_low <= 1'b1;
            end
            // Slot done: shift flags, drop any held low code byte
            if (i_cmd.advance) begin
                r_flags    <= r_flags >> 1;
                r_slot     <= r_slot - SLOT_W'(1);
                r_code_low <= '0;
                r_have_low <= 1'b0;
            end
            if (i_cmd.emit_lit || i_cmd.emit_copy) begin
                r_pos <= r_pos + LEN_W'(1);
            end
        end
    end

    // Copy sequencing
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_copy) begin
            r_count <= CNT_W'(r_byte[BYTE_W-1:BYTE_W-4]) + COPY_MIN;
            r_off   <= {r_byte[3:0], r_code_low};
            r_idx   <= '0;
        end else if (i_cmd.emit_copy) begin
            r_idx <= r_idx + CNT_W'(1);
        end
        if (i_cmd.copy_read) begin
            r_src_ok <= (src < r_pos);
        end
    end

    // History window
    assign ram_we    = i_cmd.emit_lit || i_cmd.emit_copy;
    assign ram_wdata = i_cmd.emit_lit ? r_byte : copy_byte;

    lfnd_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (WIN_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos[WIN_AW-1:0]),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.copy_read),
        .i_raddr (src[WIN_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_lit || i_cmd.emit_copy || i_cmd.emit_final) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_lit) begin
            r_out.out_byte   <= r_byte;
            r_out.run_end    <= !r_last;
            r_out.final_flag <= 1'b0;
            r_out.out_length <= '0;
        end else if (i_cmd.emit_copy) begin
            r_out.out_byte   <= copy_byte;
            r_out.run_end    <= !r_last && copy_last;
            r_out.final_flag <= 1'b0;
            r_out.out_length <= '0;
        end else if (i_cmd.emit_final) begin
            r_out.out_byte   <= '0;
            r_out.run_end    <= 1'b1;
            r_out.final_flag <= 1'b1;
            r_out.out_length <= r_pos;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

`default_nettype wire
